### src/rmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg: shared definitions of the range match type table
// Codes, default sizes and the entry and query records that move along the
// chain of table cells.
// ----------------------------------------------------------------------------
package rmt_pkg;

    // Default number of table cells.
    localparam int TABLE_DEPTH_DEF = 128;

    // Field widths fixed by the item format.
    localparam int CODE_W = 16;
    localparam int KIND_W = 16;
    localparam int MASK_W = 6;
    localparam int CAT_W  = 2;
    localparam int STAT_W = 2;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Category codes.
    localparam logic [CAT_W-1:0] CAT_POINT   = 2'd0;
    localparam logic [CAT_W-1:0] CAT_LINE    = 2'd1;
    localparam logic [CAT_W-1:0] CAT_AREA    = 2'd2;
    localparam logic [CAT_W-1:0] CAT_INVALID = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADCAT = 2'd2;

    // One table entry, held by one cell.
    typedef struct packed {
        logic [CODE_W-1:0] low;
        logic [CODE_W-1:0] high;
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        logic [CAT_W-1:0]  group;
    } t_entry;

    // A lookup in flight, with the best match found so far.
    typedef struct packed {
        logic              valid;
        logic [CAT_W-1:0]  cat;
        logic [CODE_W-1:0] code;
        logic              found;
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
    } t_query;

endpackage

### src/rmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_cell: one cell of the range table
// Holds one entry, shifts it to the next cell on insert, and checks a passing
// lookup against that entry before handing the lookup on.
// ----------------------------------------------------------------------------
module rmt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_live,
    input  rmt_pkg::t_entry i_entry,
    output rmt_pkg::t_entry o_entry,
    input  rmt_pkg::t_query i_query,
    output rmt_pkg::t_query o_query
);

    rmt_pkg::t_entry r_entry;
    rmt_pkg::t_query r_query;
    rmt_pkg::t_query n_query;
    logic            w_point_hit;
    logic            w_range_hit;
    logic            w_hit;

    // Entry storage: a new entry pushes the older ones one cell down.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    // Match test of the passing lookup against the held entry.
    assign w_point_hit = (r_entry.high == '0) && (r_entry.low == i_query.code);
    assign w_range_hit = (r_entry.low <= i_query.code) && (i_query.code <= r_entry.high);
    assign w_hit       = i_live && i_query.valid && !i_query.found &&
                         (r_entry.group == i_query.cat) && (w_point_hit || w_range_hit);

    // The first hit along the chain is the newest entry, so later cells keep it.
    always_comb begin
        n_query = i_query;
        if (w_hit) begin
            n_query.found = 1'b1;
            n_query.kind  = r_entry.kind;
            n_query.mask  = r_entry.mask;
        end
    end

    // Lookup stage register; only the valid flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query.valid <= 1'b0;
        end else begin
            r_query <= n_query;
        end
    end

    assign o_entry = r_entry;
    assign o_query = r_query;

endmodule

### src/range_match_type_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_match_type_table: newest-first code range classifier
// Table of code ranges per category, searched by a chain of cells.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells; an insert pushes the new entry into
// the first cell and every older entry one cell further, so the first cell
// always holds the newest entry. A lookup enters the first cell and moves one
// cell per clock; the first matching cell it passes is the winner. The block
// works on one item at a time: an insert or an item with a bad category passes
// through S_FINISH before the next item can be taken, and a lookup first waits
// in S_SEARCH for its walk through the chain to end. One result item is
// returned for every input item, held in an output register until it is
// taken, so a slow consumer only stalls the block once a second result is
// ready. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module range_match_type_table #(
    parameter int TABLE_DEPTH = rmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_opcode,
    input  logic [rmt_pkg::CAT_W-1:0]  i_category,
    input  logic [rmt_pkg::CODE_W-1:0] i_code_low,
    input  logic [rmt_pkg::CODE_W-1:0] i_code_high,
    input  logic [rmt_pkg::KIND_W-1:0] i_kind_in,
    input  logic [rmt_pkg::MASK_W-1:0] i_mask_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [rmt_pkg::KIND_W-1:0] o_kind_out,
    output logic [rmt_pkg::MASK_W-1:0] o_mask_out,
    output logic [rmt_pkg::STAT_W-1:0] o_status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_res_found;
    logic [rmt_pkg::KIND_W-1:0] r_res_kind;
    logic [rmt_pkg::MASK_W-1:0] r_res_mask;
    logic [rmt_pkg::STAT_W-1:0] r_res_status;
    logic                       r_out_valid;
    logic                       r_out_found;
    logic [rmt_pkg::KIND_W-1:0] r_out_kind;
    logic [rmt_pkg::MASK_W-1:0] r_out_mask;
    logic [rmt_pkg::STAT_W-1:0] r_out_status;

    logic w_accept;
    logic w_bad;
    logic w_insert;
    logic w_full;
    logic w_shift;
    logic w_can_load;

    rmt_pkg::t_entry w_entry [TABLE_DEPTH+1];
    rmt_pkg::t_query w_query [TABLE_DEPTH+1];

    // Input decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_bad      = (i_category == rmt_pkg::CAT_INVALID);
    assign w_insert   = (i_opcode == rmt_pkg::OP_INSERT);
    assign w_full     = (r_fill == CNT_W'(TABLE_DEPTH));
    assign w_shift    = w_accept && !w_bad && w_insert && !w_full;
    assign w_can_load = !r_out_valid || i_out_ready;

    // New entry at the head of the chain; a line entry keeps a single code.
    always_comb begin
        w_entry[0].low   = i_code_low;
        w_entry[0].high  = (i_category == rmt_pkg::CAT_LINE) ? '0 : i_code_high;
        w_entry[0].kind  = i_kind_in;
        w_entry[0].mask  = i_mask_in;
        w_entry[0].group = i_category;
    end

    // Lookup injected into the head of the chain.
    always_comb begin
        w_query[0].valid = w_accept && !w_bad && !w_insert;
        w_query[0].cat   = i_category;
        w_query[0].code  = i_code_low;
        w_query[0].found = 1'b0;
        w_query[0].kind  = '0;
        w_query[0].mask  = '0;
    end

    // The chain of cells; a cell is live once an entry has reached it.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_live  (r_fill > CNT_W'(g)),
            .i_entry (w_entry[g]),
            .o_entry (w_entry[g+1]),
            .i_query (w_query[g]),
            .o_query (w_query[g+1])
        );
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_shift) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // Sequencer: wait for the lookup to leave the chain, then hand over the result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (!w_bad && !w_insert) ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH: begin
                if (w_query[TABLE_DEPTH].valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pending result of the current item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_found <= 1'b0;
            r_res_kind  <= '0;
            r_res_mask  <= '0;
            if (w_bad) begin
                r_res_status <= rmt_pkg::ST_BADCAT;
            end else if (w_insert && w_full) begin
                r_res_status <= rmt_pkg::ST_FULL;
            end else begin
                r_res_status <= rmt_pkg::ST_OK;
            end
        end else if (r_state == S_SEARCH && w_query[TABLE_DEPTH].valid) begin
            r_res_found  <= w_query[TABLE_DEPTH].found;
            r_res_kind   <= w_query[TABLE_DEPTH].kind;
            r_res_mask   <= w_query[TABLE_DEPTH].mask;
            r_res_status <= rmt_pkg::ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && w_can_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && w_can_load) begin
            r_out_found  <= r_res_found;
            r_out_kind   <= r_res_kind;
            r_out_mask   <= r_res_mask;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_kind_out  = r_out_kind;
    assign o_mask_out  = r_out_mask;
    assign o_status    = r_out_status;

endmodule

### src/rmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_checker: port-level checks of the range match type table
// Watches the top-level ports and flags results or handshakes that break the
// block's rules.
// ----------------------------------------------------------------------------
module rmt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_found,
    input logic [rmt_pkg::KIND_W-1:0] o_kind_out,
    input logic [rmt_pkg::MASK_W-1:0] o_mask_out,
    input logic [rmt_pkg::STAT_W-1:0] o_status
);

    // A result waiting for the consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result item dropped before it was taken");

    // A miss reports zero kind and mask.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_kind_out == '0 && o_mask_out == '0))
        else $error("miss with nonzero kind or mask");

    // A hit only comes from a good lookup.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == rmt_pkg::ST_OK))
        else $error("hit reported with error status");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

endmodule

bind range_match_type_table rmt_checker u_rmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_found     (o_found),
    .o_kind_out  (o_kind_out),
    .o_mask_out  (o_mask_out),
    .o_status    (o_status)
);

### test/range_match_type_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_match_type_table_checker: result checker for the range match table
// Watches both channels of the table, keeps its own copy of the entries,
// works out the answer to every accepted item and compares it, field by
// field, with the result items that the block returns, in order.
// ----------------------------------------------------------------------------
module range_match_type_table_checker #(
    parameter int TABLE_DEPTH = rmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_opcode,
    input  logic [rmt_pkg::CAT_W-1:0]  i_category,
    input  logic [rmt_pkg::CODE_W-1:0] i_code_low,
    input  logic [rmt_pkg::CODE_W-1:0] i_code_high,
    input  logic [rmt_pkg::KIND_W-1:0] i_kind_in,
    input  logic [rmt_pkg::MASK_W-1:0] i_mask_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_found,
    input  logic [rmt_pkg::KIND_W-1:0] i_kind_out,
    input  logic [rmt_pkg::MASK_W-1:0] i_mask_out,
    input  logic [rmt_pkg::STAT_W-1:0] i_status,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_hits,
    output int                         o_full_drops,
    output int                         o_bad_cats
);

    import rmt_pkg::*;

    // One answer as the block should return it.
    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        logic [STAT_W-1:0] status;
    } t_answer;

    // Shadow copy of the table, oldest entry at index 0.
    t_entry  shadow_entries [TABLE_DEPTH];
    int      shadow_count = 0;
    t_answer answers_due [$];

    int fail_count = 0;
    int pending    = 0;
    int hits       = 0;
    int full_drops = 0;
    int bad_cats   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_hits       = hits;
    assign o_full_drops = full_drops;
    assign o_bad_cats   = bad_cats;

    // Apply one item to the shadow table and return the answer it must give.
    function automatic t_answer classify_item(
        input logic              op,
        input logic [CAT_W-1:0]  cat,
        input logic [CODE_W-1:0] code,
        input logic [CODE_W-1:0] code_top,
        input logic [KIND_W-1:0] kind,
        input logic [MASK_W-1:0] mask
    );
        t_answer ans;
        t_entry  ent;
        ans = '0;
        if (cat == CAT_INVALID) begin
            // A bad category wins over a full table, for inserts and lookups.
            ans.status = ST_BADCAT;
            bad_cats++;
        end else if (op == OP_INSERT) begin
            if (shadow_count >= TABLE_DEPTH) begin
                ans.status = ST_FULL;
                full_drops++;
            end else begin
                // Line entries always match a single code.
                ent.low   = code;
                ent.high  = (cat == CAT_LINE) ? '0 : code_top;
                ent.kind  = kind;
                ent.mask  = mask;
                ent.group = cat;
                shadow_entries[shadow_count] = ent;
                shadow_count++;
            end
        end else begin
            // Search newest first; the first match of the category wins.
            for (int i = shadow_count - 1; i >= 0; i--) begin
                if (!ans.found && shadow_entries[i].group == cat &&
                    ((shadow_entries[i].high == '0 && shadow_entries[i].low == code) ||
                     (shadow_entries[i].low <= code && code <= shadow_entries[i].high))) begin
                    ans.found = 1'b1;
                    ans.kind  = shadow_entries[i].kind;
                    ans.mask  = shadow_entries[i].mask;
                end
            end
            if (ans.found) begin
                hits++;
            end
        end
        return ans;
    endfunction

    // Retire results first, then record the item taken at the same edge.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result item: found %0d kind %0d mask %0d status %0d",
                           i_found, i_kind_out, i_mask_out, i_status);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d", want.found, i_found);
                        fail_count++;
                    end
                    if (i_kind_out !== want.kind) begin
                        $error("kind_out mismatch: expected %0d, actual %0d",
                               want.kind, i_kind_out);
                        fail_count++;
                    end
                    if (i_mask_out !== want.mask) begin
                        $error("mask_out mismatch: expected %0d, actual %0d",
                               want.mask, i_mask_out);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                answers_due.push_back(classify_item(i_opcode, i_category, i_code_low,
                                                    i_code_high, i_kind_in, i_mask_in));
            end
            pending = answers_due.size();
        end
    end

endmodule

### test/range_match_type_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_match_type_table_test: testbench of the range match type table
// Drives a directed set of inserts and lookups over the code extremes and
// the category rules, then random traffic that mostly looks up codes near
// stored ranges and goes on past a full table, with random gaps on both channels.
// ----------------------------------------------------------------------------
module range_match_type_table_test;

    import rmt_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_LIMIT  = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_opcode;
    logic [CAT_W-1:0]  i_category;
    logic [CODE_W-1:0] i_code_low;
    logic [CODE_W-1:0] i_code_high;
    logic [KIND_W-1:0] i_kind_in;
    logic [MASK_W-1:0] i_mask_in;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_found;
    logic [KIND_W-1:0] o_kind_out;
    logic [MASK_W-1:0] o_mask_out;
    logic [STAT_W-1:0] o_status;

    int fail_count;
    int pending;
    int hits;
    int full_drops;
    int bad_cats;

    int idle_pct   = 17;
    int item_count = 0;
    int quiet      = 0;

    // Ranges stored so far, used to aim lookups at live entries.
    int               stored_low [$];
    int               stored_high [$];
    logic [CAT_W-1:0] stored_cat [$];

    range_match_type_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_category (i_category),
        .i_code_low (i_code_low),
        .i_code_high(i_code_high),
        .i_kind_in  (i_kind_in),
        .i_mask_in  (i_mask_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_found    (o_found),
        .o_kind_out (o_kind_out),
        .o_mask_out (o_mask_out),
        .o_status   (o_status)
    );

    range_match_type_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_category  (i_category),
        .i_code_low  (i_code_low),
        .i_code_high (i_code_high),
        .i_kind_in   (i_kind_in),
        .i_mask_in   (i_mask_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_found     (o_found),
        .i_kind_out  (o_kind_out),
        .i_mask_out  (o_mask_out),
        .i_status    (o_status),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_full_drops(full_drops),
        .o_bad_cats  (bad_cats)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random, except during the quiet stretch.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("tb: timeout, no item moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one item at a falling edge and hold it until it is taken.
    // Called and returning at a falling edge.
    task automatic send_item(
        input logic              op,
        input logic [CAT_W-1:0]  cat,
        input logic [CODE_W-1:0] code,
        input logic [CODE_W-1:0] code_top,
        input logic [KIND_W-1:0] kind,
        input logic [MASK_W-1:0] mask
    );
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_category  <= cat;
        i_code_low  <= code;
        i_code_high <= code_top;
        i_kind_in   <= kind;
        i_mask_in   <= mask;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
        if (op == OP_INSERT && cat != CAT_INVALID) begin
            stored_low.push_back(code);
            stored_high.push_back((cat == CAT_LINE) ? 0 : code_top);
            stored_cat.push_back(cat);
        end
        @(negedge i_clk);
    endtask

    initial begin
        logic             op;
        logic [CAT_W-1:0] cat;
        int               lo;
        int               hi;
        int               k;
        int               kl;
        int               kh;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_opcode    = OP_INSERT;
        i_category  = CAT_POINT;
        i_code_low  = '0;
        i_code_high = '0;
        i_kind_in   = '0;
        i_mask_in   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, code extremes and the category rules.
        send_item(OP_LOOKUP, CAT_POINT, 16'h0000, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_INSERT, CAT_POINT, 16'h0000, 16'h0000, 16'hFFFF, 6'h3F);
        send_item(OP_LOOKUP, CAT_POINT, 16'h0000, 16'hFFFF, 16'hFFFF, 6'h3F);
        // Line entries drop their high code.
        send_item(OP_INSERT, CAT_LINE, 16'hFFFF, 16'h1234, 16'h0001, 6'h01);
        send_item(OP_LOOKUP, CAT_LINE, 16'hFFFF, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_LINE, 16'h1234, 16'h0000, 16'h0000, 6'h00);
        // Area range bounds and the codes just outside them.
        send_item(OP_INSERT, CAT_AREA, 16'd100, 16'd200, 16'h0AAA, 6'h2A);
        send_item(OP_LOOKUP, CAT_AREA, 16'd100, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'd200, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'd150, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'd99, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'd201, 16'h0000, 16'h0000, 6'h00);
        // A newer overlapping entry takes priority inside its own range only.
        send_item(OP_INSERT, CAT_AREA, 16'd150, 16'd160, 16'h5555, 6'h15);
        send_item(OP_LOOKUP, CAT_AREA, 16'd155, 16'h0000, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'd170, 16'h0000, 16'h0000, 6'h00);
        // Bad category on both operations.
        send_item(OP_INSERT, CAT_INVALID, 16'd150, 16'd150, 16'h7777, 6'h3F);
        send_item(OP_LOOKUP, CAT_INVALID, 16'd150, 16'h0000, 16'h0000, 6'h00);
        // Categories are searched apart from each other.
        send_item(OP_LOOKUP, CAT_POINT, 16'd150, 16'h0000, 16'h0000, 6'h00);
        // A high code below the low code matches nothing.
        send_item(OP_INSERT, CAT_POINT, 16'd500, 16'd400, 16'h00FF, 6'h07);
        send_item(OP_LOOKUP, CAT_POINT, 16'd500, 16'h0000, 16'h0000, 6'h00);
        // Full code span with zero kind and mask.
        send_item(OP_INSERT, CAT_AREA, 16'h0000, 16'hFFFF, 16'h0000, 6'h00);
        send_item(OP_LOOKUP, CAT_AREA, 16'hFFFF, 16'h0000, 16'h0000, 6'h00);

        // Random part: inserts that go on past a full table, lookups aimed at
        // stored ranges, a sprinkle of bad categories.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= 250 && n < 400) ? 0 : 17;
            if ($urandom_range(99) < 5) begin
                cat = CAT_INVALID;
            end else begin
                case ($urandom_range(2))
                    0: cat = CAT_POINT;
                    1: cat = CAT_LINE;
                    default: cat = CAT_AREA;
                endcase
            end
            op = ($urandom_range(99) < 35) ? OP_INSERT : OP_LOOKUP;
            if (op == OP_INSERT) begin
                lo = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(65535);
                case ($urandom_range(3))
                    0: hi = 0;
                    3: hi = $urandom_range(65535);
                    default: begin
                        hi = lo + $urandom_range(40);
                        if (hi > 65535) begin
                            hi = 65535;
                        end
                    end
                endcase
            end else begin
                hi = $urandom_range(65535);
                lo = $urandom_range(65535);
                if (stored_low.size() > 0 && $urandom_range(99) < 75) begin
                    k  = $urandom_range(stored_low.size() - 1);
                    kl = stored_low[k];
                    kh = stored_high[k];
                    if (cat != CAT_INVALID) begin
                        cat = stored_cat[k];
                    end
                    case ($urandom_range(3))
                        0: lo = kl;
                        1: lo = (kh >= kl) ? kh : kl;
                        2: lo = (kh >= kl) ? kl + $urandom_range(kh - kl) : kl;
                        default: lo = ($urandom_range(1) ? kl - 1 : kh + 1) & 16'hFFFF;
                    endcase
                end
            end
            send_item(op, cat, lo[CODE_W-1:0], hi[CODE_W-1:0],
                      KIND_W'($urandom_range(65535)), MASK_W'($urandom_range(63)));
        end
        i_in_valid <= 1'b0;
        idle_pct = 17;

        // Drain, then give the block time to show any stray result.
        while (pending != 0) @(negedge i_clk);
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);

        $display("Run covered %0d items: %0d lookup hits, %0d inserts refused on a full table,",
                 item_count, hits, full_drops);
        $display("%0d items with a bad category, %0d mismatches.", bad_cats, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
